@@ hdl/msep_pkg.sv @@
// shared types, constants and helpers for the music score event parser
`timescale 1ns / 1ps

package msep_pkg;

  localparam int          OUT_DEPTH_DEF = 4;
  localparam int          VOL_DEPTH     = 16;
  localparam logic [6:0]  VOL_RESET     = 7'd100;
  localparam logic [23:0] COUNT_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] MIN_OFFSET    = 16'd16;
  localparam logic [15:0] MIN_LUMP_LAST = 16'd15;
  localparam logic [15:0] INDEX_MAX     = 16'hFFFF;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_BEND     = 3'd2;
  localparam logic [2:0] KIND_SYSTEM   = 3'd3;
  localparam logic [2:0] KIND_CTRL     = 3'd4;
  localparam logic [2:0] KIND_SCORE_END = 3'd6;

  localparam logic RES_EVENT  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] event_tick;
    logic [2:0]  event_kind;
    logic [3:0]  event_channel;
    logic [7:0]  first_value;
    logic [6:0]  second_value;
    logic        finish_status;
    logic [23:0] event_count;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [6:0] wr_data;
    logic       clr;
  } vol_req_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = 8'h4D;
      2'd1: m = 8'h55;
      2'd2: m = 8'h53;
      default: m = 8'h1A;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/msep_vol_ram.sv @@
// per-channel volume memory with registered read and valid bits
`timescale 1ns / 1ps

module msep_vol_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  msep_pkg::vol_req_t req,
  output logic [6:0]        rd_vol
);
  import msep_pkg::*;

  logic [6:0]           mem [VOL_DEPTH];
  logic [VOL_DEPTH-1:0] valid_r;
  logic [6:0]           rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_vol = rd_valid_r ? rd_data_r : VOL_RESET;

endmodule

@@ hdl/msep_out_fifo.sv @@
// result queue taking up to two results a cycle and giving one
`timescale 1ns / 1ps

module msep_out_fifo #(
  parameter int DEPTH = msep_pkg::OUT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_a,
  input  logic          push_b,
  input  msep_pkg::res_t din_a,
  input  msep_pkg::res_t din_b,
  output logic          room,
  output logic          dout_valid,
  output msep_pkg::res_t dout,
  input  logic          pop
);
  import msep_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign wp1 = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_a && push_b) begin
      wp_nxt  = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;
      cnt_nxt = cnt_nxt + CW'(2);
    end else if (push_a) begin
      wp_nxt  = wp1;
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (pop) begin
      rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wp_r] <= din_a;
    end
    if (push_a && push_b) begin
      mem[wp1] <= din_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign room       = (cnt_r <= CW'(DEPTH - 2));
  assign dout_valid = (cnt_r != '0);
  assign dout       = mem[rp_r];

endmodule

@@ hdl/msep_core.sv @@
// byte parser: header check, event decode, tick and event count
`timescale 1ns / 1ps

module msep_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         data_byte,
  input  logic               end_of_lump,
  input  logic [6:0]         vol_rd,
  output msep_pkg::vol_req_t vol_req,
  output logic               push_a,
  output logic               push_b,
  output msep_pkg::res_t     res_a,
  output msep_pkg::res_t     res_b
);
  import msep_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_PAY1   = 3'd2;
  localparam logic [2:0] PH_PAY2   = 3'd3;
  localparam logic [2:0] PH_DELAY  = 3'd4;
  localparam logic [2:0] PH_ENDED  = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] start_r, start_nxt;
  logic        bad_r, bad_nxt;
  logic [2:0]  pkind_r, pkind_nxt;
  logic [3:0]  pch_r, pch_nxt;
  logic        pge_r, pge_nxt;
  logic [7:0]  pfirst_r, pfirst_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] dsum_r, dsum_nxt;
  logic [23:0] cnt_r, cnt_nxt;

  logic        take, after, ev, ge_eff, status_bad;
  logic [7:0]  ev_first;
  logic [6:0]  ev_second;
  logic [2:0]  ev_kind;
  logic [3:0]  ev_ch;
  logic [23:0] cnt_inc;
  res_t        ev_res, st_res;

  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 24'd1;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    start_nxt  = start_r;
    bad_nxt    = bad_r;
    pkind_nxt  = pkind_r;
    pch_nxt    = pch_r;
    pge_nxt    = pge_r;
    pfirst_nxt = pfirst_r;
    tick_nxt   = tick_r;
    dsum_nxt   = dsum_r;
    cnt_nxt    = cnt_r;
    take       = 1'b0;
    after      = 1'b0;
    ev         = 1'b0;
    ev_first   = '0;
    ev_second  = '0;
    ev_kind    = pkind_r;
    ev_ch      = pch_r;
    ge_eff     = pge_r;
    status_bad = 1'b0;
    vol_req    = '0;
    vol_req.wr_addr = pch_r;
    vol_req.wr_data = data_byte[6:0];
    if (acc) begin
      case (phase_r)
        PH_HEADER: begin
          if (idx_r < 16'd4) begin
            if (data_byte != magic_byte(idx_r[1:0])) begin
              bad_nxt = 1'b1;
            end
          end else if (idx_r == 16'd6) begin
            start_nxt[7:0] = data_byte;
          end else if (idx_r == 16'd7) begin
            start_nxt[15:8] = data_byte;
            if ({data_byte, start_r[7:0]} < MIN_OFFSET) begin
              bad_nxt = 1'b1;
            end
          end else if (idx_r >= 16'd8 && !bad_r && idx_r == start_r) begin
            take = 1'b1;
          end
        end
        PH_TYPE: begin
          take = 1'b1;
        end
        PH_PAY1: begin
          case (pkind_r)
            KIND_NOTE_OFF: begin
              ev        = 1'b1;
              ev_first  = {1'b0, data_byte[6:0]};
              ev_second = vol_rd;
              after     = 1'b1;
            end
            KIND_NOTE_ON: begin
              pfirst_nxt = {1'b0, data_byte[6:0]};
              if (data_byte[7]) begin
                phase_nxt = PH_PAY2;
              end else begin
                ev        = 1'b1;
                ev_first  = {1'b0, data_byte[6:0]};
                ev_second = vol_rd;
                after     = 1'b1;
              end
            end
            KIND_BEND: begin
              ev       = 1'b1;
              ev_first = data_byte;
              after    = 1'b1;
            end
            KIND_SYSTEM: begin
              ev       = 1'b1;
              ev_first = {1'b0, data_byte[6:0]};
              after    = 1'b1;
            end
            default: begin
              pfirst_nxt = {1'b0, data_byte[6:0]};
              phase_nxt  = PH_PAY2;
            end
          endcase
        end
        PH_PAY2: begin
          ev             = 1'b1;
          ev_first       = pfirst_r;
          ev_second      = data_byte[6:0];
          vol_req.wr_en  = (pkind_r == KIND_NOTE_ON);
          after          = 1'b1;
        end
        PH_DELAY: begin
          dsum_nxt = {dsum_r[24:0], data_byte[6:0]};
          if (!data_byte[7]) begin
            tick_nxt  = tick_r + dsum_nxt;
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
        end
      endcase

      if (take) begin
        pkind_nxt       = data_byte[6:4];
        pch_nxt         = data_byte[3:0];
        pge_nxt         = data_byte[7];
        pfirst_nxt      = '0;
        ev_kind         = data_byte[6:4];
        ev_ch           = data_byte[3:0];
        ge_eff          = data_byte[7];
        vol_req.rd_en   = 1'b1;
        vol_req.rd_addr = data_byte[3:0];
        if (data_byte[6:4] <= KIND_CTRL) begin
          phase_nxt = PH_PAY1;
        end else begin
          ev = 1'b1;
          if (data_byte[6:4] == KIND_SCORE_END) begin
            phase_nxt = PH_ENDED;
          end else begin
            after = 1'b1;
          end
        end
      end

      if (after) begin
        if (ge_eff) begin
          dsum_nxt  = '0;
          phase_nxt = PH_DELAY;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end

      if (ev) begin
        cnt_nxt = cnt_inc;
      end

      if (idx_r != INDEX_MAX) begin
        idx_nxt = idx_r + 16'd1;
      end

      status_bad = bad_nxt || idx_r < MIN_LUMP_LAST || start_nxt > idx_r;

      if (end_of_lump) begin
        vol_req.clr = 1'b1;
      end
    end
  end

  always_comb begin
    ev_res               = '0;
    ev_res.result_kind   = RES_EVENT;
    ev_res.event_tick    = tick_r;
    ev_res.event_kind    = ev_kind;
    ev_res.event_channel = ev_ch;
    ev_res.first_value   = ev_first;
    ev_res.second_value  = ev_second;
    ev_res.event_count   = cnt_inc;
    ev_res.last_of_run   = !end_of_lump;
    st_res               = '0;
    st_res.result_kind   = RES_STATUS;
    st_res.finish_status = status_bad;
    st_res.event_count   = status_bad ? '0 : cnt_nxt;
    st_res.last_of_run   = 1'b1;
    if (ev) begin
      res_a = ev_res;
    end else begin
      res_a = st_res;
    end
    res_b = st_res;
  end

  assign push_a = acc && (ev || end_of_lump);
  assign push_b = acc && ev && end_of_lump;

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && end_of_lump)) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      start_r  <= '0;
      bad_r    <= 1'b0;
      pkind_r  <= '0;
      pch_r    <= '0;
      pge_r    <= 1'b0;
      pfirst_r <= '0;
      tick_r   <= '0;
      dsum_r   <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      start_r  <= start_nxt;
      bad_r    <= bad_nxt;
      pkind_r  <= pkind_nxt;
      pch_r    <= pch_nxt;
      pge_r    <= pge_nxt;
      pfirst_r <= pfirst_nxt;
      tick_r   <= tick_nxt;
      dsum_r   <= dsum_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/music_score_event_parser_top.sv @@
// music score event parser: top level joining parser, volume memory and result queue
// each result is registered in the result queue when its request is accepted, behind any results still queued
// throughput: one byte request per cycle while in_tready is high; a final byte completing an event gives two results
// in_tready falls while the result queue has fewer than two free slots
// reset or an accepted in_tlast byte clears the parser state; channel volumes then read 100 until written
`timescale 1ns / 1ps

module music_score_event_parser_top #(
  parameter int OUT_DEPTH = msep_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_lump
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // event_tick, event_kind, event_channel, first_value,
                                  // second_value, finish_status, event_count, zero pad
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // last_of_run
);
  import msep_pkg::*;

  logic     acc, room, push_a, push_b;
  logic [6:0] vol_rd;
  vol_req_t vol_req;
  res_t     res_a, res_b, head;

  assign in_tready = room;
  assign acc       = in_tvalid && room;

  msep_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_tdata),
    .end_of_lump (in_tlast),
    .vol_rd      (vol_rd),
    .vol_req     (vol_req),
    .push_a      (push_a),
    .push_b      (push_b),
    .res_a       (res_a),
    .res_b       (res_b)
  );

  msep_vol_ram u_vol (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (vol_req),
    .rd_vol (vol_rd)
  );

  msep_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_a     (push_a),
    .push_b     (push_b),
    .din_a      (res_a),
    .din_b      (res_b),
    .room       (room),
    .dout_valid (out_tvalid),
    .dout       (head),
    .pop        (out_tvalid && out_tready)
  );

  assign out_tdata = {1'b0, head.event_count, head.finish_status, head.second_value,
                      head.first_value, head.event_channel, head.event_kind, head.event_tick};
  assign out_tuser = head.result_kind;
  assign out_tlast = head.last_of_run;

endmodule
